// ===== rtl/core/hcd_pkg.sv =====
// Shared types, constants and helpers of the chunked body decoder.
`timescale 1ns / 1ps

package hcd_pkg;

  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  // Status carried by an end record.
  typedef enum logic [1:0] {
    END_OK          = 2'd0,
    END_NO_LINE_END = 2'd1,
    END_TRUNCATED   = 2'd2,
    END_OVERFLOW    = 2'd3
  } end_status_e;

  // Parsing phase of the front part.
  typedef enum logic [3:0] {
    PH_SIZE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_DRAIN = 4'b1000
  } phase_e;

  // One queued command: an optional data word followed by an optional end word.
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        has_end;
    logic [31:0] total;
    end_status_e status;
  } cmd_t;

  // Result of decoding one ASCII hex digit.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t h;
    h = '0;
    case (b) inside
      [8'h30:8'h39]: begin
        h.valid = 1'b1;
        h.value = b[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        h.valid = 1'b1;
        h.value = b[3:0] + 4'd9;
      end
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/core/hcd_if.sv =====
// Stream interfaces for the input bytes and the decoded result words.
`timescale 1ns / 1ps

interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface hcd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_end;
  logic [31:0] total_length;
  logic [1:0]  end_status;

  modport source (output valid, output out_byte, output is_end, output total_length,
                  output end_status, input ready);
  modport sink (input valid, input out_byte, input is_end, input total_length,
                input end_status, output ready);
endinterface

// ===== rtl/core/hcd_front.sv =====
// Front part: parses chunk framing and turns data bytes and end records into commands.
`timescale 1ns / 1ps

module hcd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          push_o,
  output hcd_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  import hcd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        prev_cr_q, prev_cr_d;
  logic [30:0] size_q, size_d;
  logic        hex_stop_q, hex_stop_d;
  logic        ovf_q, ovf_d;
  logic [30:0] left_q, left_d;
  logic [1:0]  skip_q, skip_d;
  logic [31:0] total_q, total_d;

  logic        fire;
  logic        end_now;
  end_status_e status;
  hex_t        hv;
  logic [30:0] left_dec;
  logic [1:0]  skip_dec;
  logic [31:0] total_inc;
  cmd_t        cmd;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;
  assign hv         = hex_decode(in_byte_i);
  assign left_dec   = left_q - 31'd1;
  assign skip_dec   = skip_q - 2'd1;
  assign total_inc  = (total_q == '1) ? total_q : total_q + 32'd1;

  // Next-state logic of the framing parser.
  always_comb begin
    phase_d    = phase_q;
    prev_cr_d  = prev_cr_q;
    size_d     = size_q;
    hex_stop_d = hex_stop_q;
    ovf_d      = ovf_q;
    left_d     = left_q;
    skip_d     = skip_q;
    total_d    = total_q;
    end_now    = 1'b0;
    status     = END_OK;
    cmd        = '0;

    if (fire) begin
      case (phase_q)
        PH_DRAIN: begin
          // Trailing bytes after an end record are dropped until the last one.
          if (in_last_i) begin
            phase_d = PH_SIZE;
            total_d = '0;
          end
        end
        PH_DATA: begin
          cmd.has_data = 1'b1;
          cmd.data     = in_byte_i;
          total_d      = total_inc;
          left_d       = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_SKIP;
            skip_d  = 2'd2;
          end
          if (in_last_i) begin
            end_now = 1'b1;
            status  = (left_dec != '0) ? END_TRUNCATED : END_NO_LINE_END;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d    = PH_SIZE;
            prev_cr_d  = 1'b0;
            size_d     = '0;
            hex_stop_d = 1'b0;
            ovf_d      = 1'b0;
          end
          if (in_last_i) begin
            end_now = 1'b1;
            status  = END_NO_LINE_END;
          end
        end
        PH_SIZE: begin
          if (prev_cr_q && in_byte_i == ByteLf) begin
            // Size line complete.
            if (ovf_q) begin
              end_now = 1'b1;
              status  = END_OVERFLOW;
            end else if (size_q == '0) begin
              end_now = 1'b1;
              status  = END_OK;
            end else begin
              left_d     = size_q;
              phase_d    = PH_DATA;
              prev_cr_d  = 1'b0;
              size_d     = '0;
              hex_stop_d = 1'b0;
              ovf_d      = 1'b0;
              if (in_last_i) begin
                end_now = 1'b1;
                status  = END_TRUNCATED;
              end
            end
          end else begin
            // Accumulate leading hex digits; the first other byte freezes the size.
            if (!hex_stop_q) begin
              if (!hv.valid) begin
                hex_stop_d = 1'b1;
              end else if (!ovf_q) begin
                if (size_q[30:27] != '0) begin
                  ovf_d = 1'b1;
                end else begin
                  size_d = {size_q[26:0], hv.value};
                end
              end
            end
            prev_cr_d = (in_byte_i == ByteCr);
            if (in_last_i) begin
              end_now = 1'b1;
              status  = END_NO_LINE_END;
            end
          end
        end
        default: phase_d = PH_SIZE;
      endcase

      // An end record closes the body; the last word restarts the parser.
      if (end_now) begin
        cmd.has_end = 1'b1;
        cmd.total   = total_d;
        cmd.status  = status;
        if (in_last_i) begin
          phase_d = PH_SIZE;
          total_d = '0;
        end else begin
          phase_d = PH_DRAIN;
        end
      end

      if (in_last_i) begin
        prev_cr_d  = 1'b0;
        size_d     = '0;
        hex_stop_d = 1'b0;
        ovf_d      = 1'b0;
        left_d     = '0;
        skip_d     = '0;
      end
    end
  end

  assign push_o = fire && (cmd.has_data || cmd.has_end);
  assign cmd_o  = cmd;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIZE;
      prev_cr_q  <= 1'b0;
      size_q     <= '0;
      hex_stop_q <= 1'b0;
      ovf_q      <= 1'b0;
      left_q     <= '0;
      skip_q     <= '0;
      total_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      prev_cr_q  <= prev_cr_d;
      size_q     <= size_d;
      hex_stop_q <= hex_stop_d;
      ovf_q      <= ovf_d;
      left_q     <= left_d;
      skip_q     <= skip_d;
      total_q    <= total_d;
    end
  end

endmodule

// ===== rtl/core/hcd_queue.sv =====
// Short command queue between the parser and the result stage.
`timescale 1ns / 1ps

module hcd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hcd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hcd_pkg::cmd_t head_o
);
  import hcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/hcd_back.sv =====
// Back part: expands queued commands into data and end words on the output register.
`timescale 1ns / 1ps

module hcd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  hcd_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          is_end_o,
  output logic [31:0]   total_length_o,
  output logic [1:0]    end_status_o
);
  import hcd_pkg::*;

  logic        valid_q, valid_d;
  logic        sent_q, sent_d;
  logic        load;
  logic        emit_data;
  logic [7:0]  byte_q;
  logic        end_q;
  logic [31:0] total_q;
  logic [1:0]  status_q;

  assign load      = !valid_q || out_ready_i;
  assign emit_data = head_i.has_data && !sent_q;

  // Choose the next word: the data word of a command first, then its end word.
  always_comb begin
    valid_d = valid_q;
    sent_d  = sent_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (emit_data && head_i.has_end) begin
          sent_d = 1'b1;
        end else begin
          pop_o  = 1'b1;
          sent_d = 1'b0;
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      if (emit_data) begin
        byte_q   <= head_i.data;
        end_q    <= 1'b0;
        total_q  <= '0;
        status_q <= END_OK;
      end else begin
        byte_q   <= '0;
        end_q    <= 1'b1;
        total_q  <= head_i.total;
        status_q <= head_i.status;
      end
    end
  end

  // Output valid and the data-sent mark of the head command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign is_end_o       = end_q;
  assign total_length_o = total_q;
  assign end_status_o   = status_q;

endmodule

// ===== rtl/core/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
//
//   Port   Direction  Word                     Handshake
//   in_i   sink       in_byte, in_last         valid/ready
//   out_o  source     out_byte, is_end,        valid/ready
//                     total_length, end_status
//
// One input word is taken every cycle while the command queue has room.
// A data word with an end record leaves as two output words, data first;
// the result register then sets the sustained rate of such commands.
// Reset is asynchronous and active low and leaves the parser looking for a
// size line. Either side may stall; the queue of QueueDepth commands lets
// the parser run ahead of the output.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcd_in_if.sink    in_i,
  hcd_out_if.source out_o
);
  import hcd_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd, head;

  hcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .in_ready_o (in_i.ready),
    .push_o     (push),
    .cmd_o      (cmd),
    .full_i     (full)
  );

  hcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  hcd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_byte_o     (out_o.out_byte),
    .is_end_o       (out_o.is_end),
    .total_length_o (out_o.total_length),
    .end_status_o   (out_o.end_status)
  );

endmodule

// ===== rtl/core/hcd_checker.sv =====
// Port-level checks of the chunked body decoder and their binding.
`timescale 1ns / 1ps

module hcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        is_end_i,
  input logic [31:0] total_length_i,
  input logic [1:0]  end_status_i
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word withdrawn while stalled");

  // A stalled end record keeps its count and status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && is_end_i
    |=> is_end_i && $stable(total_length_i) && $stable(end_status_i))
    else $error("end record changed while stalled");

  // A data word carries no count and no status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> total_length_i == '0 && end_status_i == '0)
    else $error("data word with count or status");

  // An end record carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> out_byte_i == '0)
    else $error("end record with nonzero byte");

endmodule

bind http_chunked_body_decoder hcd_checker u_hcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .is_end_i       (out_o.is_end),
  .total_length_i (out_o.total_length),
  .end_status_i   (out_o.end_status)
);

// ===== verif/http_chunked_body_decoder_test.sv =====
// Self-checking testbench for the chunked body decoder: directed rows, then random bodies.
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;
  import hcd_pkg::*;

  localparam int DirectedRows = 26;
  localparam int RandomWords  = 1750;
  localparam int CycleLimit   = 100000;
  localparam logic [30:0] SizeShiftMax = 31'h07FF_FFFF;

  // One expected output word.
  typedef struct packed {
    logic [7:0]  data;
    logic        closing;
    logic [31:0] total;
    end_status_e status;
  } decoded_t;

  // One directed input word, with the end record typed in where it is obvious.
  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    end_status_e st;
    logic [31:0] tot;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcd_in_if  in_bus ();
  hcd_out_if out_bus ();

  http_chunked_body_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Decoder state as predicted from the input words.
  phase_e      dec_phase;
  logic        cr_seen;
  logic [30:0] size_acc;
  logic        hex_done;
  logic        size_ovf;
  logic [30:0] chunk_left;
  logic [1:0]  skip_cnt;
  logic [31:0] body_total;
  logic        body_done;

  decoded_t    decoded_q [$];
  logic [7:0]  frame_q [$];
  int          mismatches = 0;
  int          words_sent = 0;
  int unsigned cycles = 0;
  logic        calm = 1'b0;

  // Short bodies covering each ending, the extremes of the data byte and the
  // words that follow an end record.
  stim_row_t directed_rows [DirectedRows] = '{
    '{"0",    1'b0, 1'b0, END_OK,          32'd0},
    '{ByteCr, 1'b0, 1'b0, END_OK,          32'd0},
    '{ByteLf, 1'b0, 1'b1, END_OK,          32'd0},
    '{8'h00,  1'b1, 1'b0, END_OK,          32'd0},
    '{"1",    1'b0, 1'b0, END_OK,          32'd0},
    '{";",    1'b0, 1'b0, END_OK,          32'd0},
    '{ByteCr, 1'b0, 1'b0, END_OK,          32'd0},
    '{ByteLf, 1'b0, 1'b0, END_OK,          32'd0},
    '{8'hFF,  1'b0, 1'b0, END_OK,          32'd0},
    '{ByteCr, 1'b0, 1'b0, END_OK,          32'd0},
    '{ByteLf, 1'b1, 1'b1, END_NO_LINE_END, 32'd1},
    '{"2",    1'b0, 1'b0, END_OK,          32'd0},
    '{ByteCr, 1'b0, 1'b0, END_OK,          32'd0},
    '{ByteLf, 1'b0, 1'b0, END_OK,          32'd0},
    '{8'h00,  1'b1, 1'b1, END_TRUNCATED,   32'd1},
    '{"x",    1'b1, 1'b1, END_NO_LINE_END, 32'd0},
    '{"f",    1'b0, 1'b0, END_OK,          32'd0},
    '{"F",    1'b0, 1'b0, END_OK,          32'd0},
    '{"f",    1'b0, 1'b0, END_OK,          32'd0},
    '{"F",    1'b0, 1'b0, END_OK,          32'd0},
    '{"f",    1'b0, 1'b0, END_OK,          32'd0},
    '{"F",    1'b0, 1'b0, END_OK,          32'd0},
    '{"f",    1'b0, 1'b0, END_OK,          32'd0},
    '{"F",    1'b0, 1'b0, END_OK,          32'd0},
    '{ByteCr, 1'b0, 1'b0, END_OK,          32'd0},
    '{ByteLf, 1'b1, 1'b1, END_OVERFLOW,    32'd0}
  };

  // Clock with a period of 2 ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Value of an ASCII hex digit, or -1 for any other byte.
  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic void clear_line();
    cr_seen  = 1'b0;
    size_acc = '0;
    hex_done = 1'b0;
    size_ovf = 1'b0;
  endfunction

  function automatic void clear_decoder();
    dec_phase  = PH_SIZE;
    clear_line();
    chunk_left = '0;
    skip_cnt   = '0;
    body_total = '0;
    body_done  = 1'b0;
  endfunction

  // Advances the predicted state by one accepted input word and queues the
  // output words that it causes.
  function automatic void decode_byte(logic [7:0] b, logic l);
    logic        closing;
    end_status_e st;
    int          nib;
    closing = 1'b0;
    st      = END_OK;
    if (body_done) begin
      if (l) clear_decoder();
      return;
    end
    case (dec_phase)
      PH_DATA: begin
        decoded_q.push_back('{b, 1'b0, 32'd0, END_OK});
        if (body_total != '1) body_total++;
        if (chunk_left != '0) chunk_left--;
        if (chunk_left == '0) begin
          dec_phase = PH_SKIP;
          skip_cnt  = 2'd2;
        end
        if (l) begin
          closing = 1'b1;
          st = (chunk_left != '0) ? END_TRUNCATED : END_NO_LINE_END;
        end
      end
      PH_SKIP: begin
        if (skip_cnt != '0) skip_cnt--;
        if (skip_cnt == '0) begin
          dec_phase = PH_SIZE;
          clear_line();
        end
        if (l) begin
          closing = 1'b1;
          st = END_NO_LINE_END;
        end
      end
      default: begin
        if (cr_seen && b == ByteLf) begin
          if (size_ovf) begin
            closing = 1'b1;
            st = END_OVERFLOW;
          end else if (size_acc == '0) begin
            closing = 1'b1;
            st = END_OK;
          end else begin
            chunk_left = size_acc;
            dec_phase  = PH_DATA;
            clear_line();
            if (l) begin
              closing = 1'b1;
              st = END_TRUNCATED;
            end
          end
        end else begin
          // Hex digits accumulate until the first other byte of the line.
          if (!hex_done) begin
            nib = nibble_of(b);
            if (nib < 0) begin
              hex_done = 1'b1;
            end else if (!size_ovf) begin
              if (size_acc > SizeShiftMax) size_ovf = 1'b1;
              else size_acc = {size_acc[26:0], nib[3:0]};
            end
          end
          cr_seen = (b == ByteCr);
          if (l) begin
            closing = 1'b1;
            st = END_NO_LINE_END;
          end
        end
      end
    endcase
    if (closing) begin
      decoded_q.push_back('{8'h00, 1'b1, body_total, st});
      if (l) clear_decoder();
      else body_done = 1'b1;
    end
  endfunction

  // Offers one word, waits for it to be taken and predicts its results.
  task automatic send_word(logic [7:0] b, logic l);
    while (!calm && $urandom_range(99) < 19) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    in_bus.in_last <= l;
    do @(posedge clk_i); while (!in_bus.ready);
    decode_byte(b, l);
    words_sent++;
    calm = (words_sent >= 700 && words_sent < 1000);
  endtask

  // Framing bytes with a fair share of fully random ones.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0: return ByteCr;
      1: return ByteLf;
      2: return "0";
      3: return "a";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Appends a size line in hex of random case, with optional leading zeros
  // and an optional extension.
  function automatic void push_size_line(logic [35:0] sz);
    int         digits;
    logic [3:0] nib;
    digits = 1;
    for (int i = 1; i < 9; i++) if (sz[4*i +: 4] != '0) digits = i + 1;
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) frame_q.push_back("0");
    for (int i = digits - 1; i >= 0; i--) begin
      nib = sz[4*i +: 4];
      if (nib < 4'd10) frame_q.push_back(8'h30 + 8'(nib));
      else frame_q.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
    end
    if ($urandom_range(3) == 0) begin
      frame_q.push_back(";");
      repeat ($urandom_range(4)) frame_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
    end
    frame_q.push_back(ByteCr);
    frame_q.push_back(ByteLf);
  endfunction

  // Builds one body, mostly well formed, sometimes cut short or pure noise,
  // and sends it with the last flag on its final byte.
  task automatic send_body();
    logic [35:0] sz;
    int          n_chunks;
    int          n_data;
    int          cut;
    logic        stop;
    frame_q.delete();
    stop = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(6, 1)) frame_q.push_back(noise_byte());
    end else begin
      n_chunks = $urandom_range(3);
      for (int k = 0; k < n_chunks && !stop; k++) begin
        case ($urandom_range(19))
          0: sz = {4'h1, 32'($urandom)};
          1: sz = 36'($urandom_range(32'h7FFF_FFFF, 32'h100));
          2, 3: sz = 36'($urandom_range(60, 13));
          default: sz = 36'($urandom_range(12, 1));
        endcase
        push_size_line(sz);
        if (sz > 36'h7FFF_FFFF) begin
          // An oversized line ends the body; only trailing bytes follow.
          stop = 1'b1;
          repeat ($urandom_range(3)) frame_q.push_back(noise_byte());
        end else begin
          // A large chunk is always cut off inside its data.
          stop   = (sz > 36'd60);
          n_data = stop ? $urandom_range(20, 1) : int'(sz);
          repeat (n_data) frame_q.push_back(8'($urandom_range(255)));
          if (!stop) begin
            if ($urandom_range(6) != 0) begin
              frame_q.push_back(ByteCr);
              frame_q.push_back(ByteLf);
            end else begin
              repeat (2) frame_q.push_back(8'($urandom_range(255)));
            end
          end
        end
      end
      if (!stop) begin
        if ($urandom_range(6) == 0) begin
          frame_q.push_back(ByteCr);
          frame_q.push_back(ByteLf);
        end else begin
          push_size_line('0);
        end
        repeat ($urandom_range(3)) frame_q.push_back(noise_byte());
      end
      if ($urandom_range(6) == 0) begin
        cut = $urandom_range(frame_q.size() - 1);
        frame_q = frame_q[0:cut];
      end
    end
    foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Output side stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_bus.ready <= calm || ($urandom_range(99) >= 19);
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Each word taken from the output is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_words
    decoded_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte 0x%0h end %0b total %0d",
                 $time, out_bus.out_byte, out_bus.is_end, out_bus.total_length);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", 32'(want.data), 32'(out_bus.out_byte));
        check_field("is_end", 32'(want.closing), 32'(out_bus.is_end));
        check_field("total_length", want.total, out_bus.total_length);
        check_field("end_status", 32'(want.status), 32'(out_bus.end_status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reset, directed rows, random bodies, then drain and report.
  initial begin
    stim_row_t row;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    rst_ni         = 1'b0;
    clear_decoder();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.b, row.l);
      if (row.typed) decoded_q[decoded_q.size() - 1] = '{8'h00, 1'b1, row.tot, row.st};
    end
    while (words_sent < DirectedRows + RandomWords) send_body();
    in_bus.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hcd_pkg.sv
rtl/core/hcd_if.sv
rtl/core/hcd_front.sv
rtl/core/hcd_queue.sv
rtl/core/hcd_back.sv
rtl/core/http_chunked_body_decoder.sv
rtl/core/hcd_checker.sv
verif/http_chunked_body_decoder_test.sv
